// ===== rtl/core/cyclic_dominance_lattice_update_top_macros.svh =====
// Assertion wrappers; empty when SYNTH is defined.
`ifndef CYCLIC_DOMINANCE_LATTICE_UPDATE_TOP_MACROS_SVH
`define CYCLIC_DOMINANCE_LATTICE_UPDATE_TOP_MACROS_SVH
`ifndef SYNTH
`define CDL_ASSERT_IMPL(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("same-cycle check failed");
`define CDL_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("next-cycle check failed");
`else
`define CDL_ASSERT_IMPL(lbl, clk, rstn, pre, post)
`define CDL_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

// ===== rtl/core/cdl_pkg.sv =====
package cdl_pkg;

    localparam int MAX_ROWS_DEF = 128;
    localparam int MAX_COLS_DEF = 128;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 24;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_UPDATE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_COUNT  = 2'd3;

    localparam logic [1:0] DIR_RIGHT = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_UP    = 2'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_STATE = 2'd2;

    localparam logic [1:0] CELL_BAD = 2'd3;

    localparam logic [1:0] CFG_ROWS     = 2'd0;
    localparam logic [1:0] CFG_COLS     = 2'd1;
    localparam logic [1:0] CFG_PROB_FWD = 2'd2;
    localparam logic [1:0] CFG_PROB_BWD = 2'd3;

    localparam logic [7:0]  ROWS_RESET = 8'd128;
    localparam logic [7:0]  COLS_RESET = 8'd128;
    localparam logic [16:0] PROB_RESET = 17'd0;

    localparam logic [14:0] COUNT_MAX = 15'h7FFF;

    typedef struct packed {
        logic [7:0]  grid_rows;
        logic [7:0]  grid_cols;
        logic [16:0] prob_forward;
        logic [16:0] prob_backward;
    } cdl_cfg_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  site_state;
        logic [1:0]  neighbour_state;
        logic        changed;
        logic [14:0] state_count;
    } cdl_result_t;

endpackage

// ===== rtl/core/cdl_ram.sv =====
module cdl_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/cdl_seq.sv =====
module cdl_seq #(
    parameter int MAX_ROWS = cdl_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = cdl_pkg::MAX_COLS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cdl_pkg::cdl_cfg_t    cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           in_op,
    input  logic [6:0]           in_row,
    input  logic [6:0]           in_col,
    input  logic [1:0]           in_dir,
    input  logic [15:0]          in_draw,
    input  logic [1:0]           in_val,
    output logic                 res_valid,
    input  logic                 res_ready,
    output cdl_pkg::cdl_result_t res
);

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int AW    = RW + CW;
    localparam int DEPTH = 1 << AW;
    localparam int RCW   = $clog2(MAX_ROWS + 1);
    localparam int CCW   = $clog2(MAX_COLS + 1);
    localparam int REW   = (RCW > 8) ? RCW : 8;
    localparam int CEW   = (CCW > 8) ? CCW : 8;

    typedef enum logic [7:0] {
        ST_CLEAR  = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_DECODE = 8'b0000_0100,
        ST_NBR    = 8'b0000_1000,
        ST_DECIDE = 8'b0001_0000,
        ST_READ   = 8'b0010_0000,
        ST_COUNT  = 8'b0100_0000,
        ST_FINISH = 8'b1000_0000
    } fsm_t;

    fsm_t state_reg, state_next;

    logic [1:0]  op_reg;
    logic [6:0]  row_reg;
    logic [6:0]  col_reg;
    logic [1:0]  dir_reg;
    logic [15:0] draw_reg;
    logic [1:0]  val_reg;

    cdl_pkg::cdl_result_t res_reg, res_next;
    logic [AW-1:0] nb_addr_reg, nb_addr_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic [RW-1:0] walk_r_reg, walk_r_next;
    logic [CW-1:0] walk_c_reg, walk_c_next;
    logic          walk_done_reg, walk_done_next;
    logic          pend_reg, pend_next;

    logic [REW-1:0] rows_ext, rows_eff, row_ext;
    logic [CEW-1:0] cols_ext, cols_eff, col_ext;
    logic [RW-1:0]  rows_last, site_r, nb_r;
    logic [CW-1:0]  cols_last, site_c, nb_c;
    logic           coord_ok;
    logic [AW-1:0]  site_addr, nb_addr;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [1:0]    ram_wdata, ram_rdata;

    logic [1:0]  site_inc, site_dec;
    logic        take;

    always_comb begin
        rows_ext = REW'(cfg.grid_rows);
        if (rows_ext == '0) begin
            rows_eff = REW'(1);
        end else if (rows_ext > REW'(MAX_ROWS)) begin
            rows_eff = REW'(MAX_ROWS);
        end else begin
            rows_eff = rows_ext;
        end
        cols_ext = CEW'(cfg.grid_cols);
        if (cols_ext == '0) begin
            cols_eff = CEW'(1);
        end else if (cols_ext > CEW'(MAX_COLS)) begin
            cols_eff = CEW'(MAX_COLS);
        end else begin
            cols_eff = cols_ext;
        end
    end

    assign rows_last = RW'(rows_eff - REW'(1));
    assign cols_last = CW'(cols_eff - CEW'(1));
    assign row_ext   = REW'(row_reg);
    assign col_ext   = CEW'(col_reg);
    assign coord_ok  = (row_ext < rows_eff) && (col_ext < cols_eff);
    assign site_r    = row_ext[RW-1:0];
    assign site_c    = col_ext[CW-1:0];
    assign site_addr = {site_r, site_c};

    always_comb begin
        nb_r = site_r;
        nb_c = site_c;
        case (dir_reg)
            cdl_pkg::DIR_RIGHT: begin
                nb_c = (site_c == cols_last) ? '0 : site_c + CW'(1);
            end
            cdl_pkg::DIR_DOWN: begin
                nb_r = (site_r == rows_last) ? '0 : site_r + RW'(1);
            end
            cdl_pkg::DIR_LEFT: begin
                nb_c = (site_c == '0) ? cols_last : site_c - CW'(1);
            end
            cdl_pkg::DIR_UP: begin
                nb_r = (site_r == '0) ? rows_last : site_r - RW'(1);
            end
            default: begin
                nb_r = site_r;
                nb_c = site_c;
            end
        endcase
    end

    assign nb_addr = {nb_r, nb_c};

    assign site_inc = (res_reg.site_state == 2'd2) ? 2'd0 : res_reg.site_state + 2'd1;
    assign site_dec = (res_reg.site_state == 2'd0) ? 2'd2 : res_reg.site_state - 2'd1;

    always_comb begin
        take = 1'b0;
        if (ram_rdata == site_inc) begin
            take = {1'b0, draw_reg} < cfg.prob_forward;
        end else if (ram_rdata == site_dec) begin
            take = {1'b0, draw_reg} < cfg.prob_backward;
        end
    end

    always_comb begin
        state_next     = state_reg;
        res_next       = res_reg;
        nb_addr_next   = nb_addr_reg;
        clr_addr_next  = clr_addr_reg;
        walk_r_next    = walk_r_reg;
        walk_c_next    = walk_c_reg;
        walk_done_next = walk_done_reg;
        pend_next      = 1'b0;
        ram_we         = 1'b0;
        ram_addr       = site_addr;
        ram_wdata      = val_reg;
        case (state_reg)
            ST_CLEAR: begin
                ram_we        = 1'b1;
                ram_addr      = clr_addr_reg;
                ram_wdata     = 2'd0;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_valid) begin
                    res_next   = '0;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (op_reg == cdl_pkg::OP_COUNT) begin
                    if (val_reg == cdl_pkg::CELL_BAD) begin
                        res_next.status = cdl_pkg::STAT_STATE;
                        state_next      = ST_FINISH;
                    end else begin
                        walk_r_next    = '0;
                        walk_c_next    = '0;
                        walk_done_next = 1'b0;
                        state_next     = ST_COUNT;
                    end
                end else if (!coord_ok) begin
                    res_next.status = cdl_pkg::STAT_RANGE;
                    state_next      = ST_FINISH;
                end else if (op_reg == cdl_pkg::OP_WRITE) begin
                    if (val_reg == cdl_pkg::CELL_BAD) begin
                        res_next.status = cdl_pkg::STAT_STATE;
                    end else begin
                        ram_we              = 1'b1;
                        res_next.site_state = val_reg;
                    end
                    state_next = ST_FINISH;
                end else if (op_reg == cdl_pkg::OP_READ) begin
                    state_next = ST_READ;
                end else begin
                    state_next = ST_NBR;
                end
            end
            ST_READ: begin
                res_next.site_state = ram_rdata;
                state_next          = ST_FINISH;
            end
            ST_NBR: begin
                res_next.site_state = ram_rdata;
                ram_addr            = nb_addr;
                nb_addr_next        = nb_addr;
                state_next          = ST_DECIDE;
            end
            ST_DECIDE: begin
                ram_addr  = nb_addr_reg;
                ram_wdata = res_reg.site_state;
                ram_we    = take;
                res_next.neighbour_state = take ? res_reg.site_state : ram_rdata;
                res_next.changed         = take;
                state_next               = ST_FINISH;
            end
            ST_COUNT: begin
                if (pend_reg && (ram_rdata == val_reg)
                        && (res_reg.state_count != cdl_pkg::COUNT_MAX)) begin
                    res_next.state_count = res_reg.state_count + 15'd1;
                end
                if (walk_done_reg) begin
                    state_next = ST_FINISH;
                end else begin
                    ram_addr  = {walk_r_reg, walk_c_reg};
                    pend_next = 1'b1;
                    if (walk_c_reg == cols_last) begin
                        walk_c_next = '0;
                        if (walk_r_reg == rows_last) begin
                            walk_done_next = 1'b1;
                        end else begin
                            walk_r_next = walk_r_reg + RW'(1);
                        end
                    end else begin
                        walk_c_next = walk_c_reg + CW'(1);
                    end
                end
            end
            ST_FINISH: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            walk_done_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            walk_done_reg <= walk_done_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            op_reg   <= in_op;
            row_reg  <= in_row;
            col_reg  <= in_col;
            dir_reg  <= in_dir;
            draw_reg <= in_draw;
            val_reg  <= in_val;
        end
        res_reg     <= res_next;
        nb_addr_reg <= nb_addr_next;
        walk_r_reg  <= walk_r_next;
        walk_c_reg  <= walk_c_next;
    end

    cdl_ram #(
        .WIDTH (2),
        .DEPTH (DEPTH)
    ) u_cells (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_FINISH);
    assign res       = res_reg;

endmodule

// ===== rtl/core/cyclic_dominance_lattice_update_top.sv =====
// Channel  Ports                          Word
// input    s_tvalid s_tready s_tdata      one operation (opcode in s_tuser)
// result   m_tvalid m_tready m_tdata      one result per operation (status in m_tuser)
// config   cfg_valid cfg_ready            cfg_index selects register, cfg_data value
//
// Write goes from accept through decode to the output register; read adds a read state, update
// a neighbour and a decide state; count walks one grid cell per cycle through the single cell memory port.
// After reset a clearing pass zeroes all 2^(clog2(MAX_ROWS)+clog2(MAX_COLS)) cells of the cell
// memory (16384 by default); s_tready stays low meanwhile, config writes are always taken.
// One output register holds a finished word; a new word is accepted while it waits on m_tready.
`include "cyclic_dominance_lattice_update_top_macros.svh"

module cyclic_dominance_lattice_update_top #(
    parameter int MAX_ROWS = cdl_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = cdl_pkg::MAX_COLS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // row[6:0], col[13:7], direction[15:14], draw[31:16], cell_value[33:32]
    input  logic [cdl_pkg::S_TDATA_W-1:0] s_tdata,
    // opcode[1:0]
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // site_state[1:0], neighbour_state[3:2], changed[4], state_count[19:5]
    output logic [cdl_pkg::M_TDATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [1:0]                    m_tuser,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [16:0]                   cfg_data
);

    cdl_pkg::cdl_cfg_t    cfg_reg, cfg_next;
    cdl_pkg::cdl_result_t res;
    cdl_pkg::cdl_result_t out_reg;
    logic                 out_valid_reg, out_valid_next;
    logic                 res_valid, res_ready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                cdl_pkg::CFG_ROWS:     cfg_next.grid_rows     = cfg_data[7:0];
                cdl_pkg::CFG_COLS:     cfg_next.grid_cols     = cfg_data[7:0];
                cdl_pkg::CFG_PROB_FWD: cfg_next.prob_forward  = cfg_data;
                cdl_pkg::CFG_PROB_BWD: cfg_next.prob_backward = cfg_data;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    assign res_ready      = !out_valid_reg || m_tready;
    assign out_valid_next = (res_valid && res_ready) || (out_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.grid_rows     <= cdl_pkg::ROWS_RESET;
            cfg_reg.grid_cols     <= cdl_pkg::COLS_RESET;
            cfg_reg.prob_forward  <= cdl_pkg::PROB_RESET;
            cfg_reg.prob_backward <= cdl_pkg::PROB_RESET;
            out_valid_reg         <= 1'b0;
        end else begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    cdl_seq #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_row    (s_tdata[6:0]),
        .in_col    (s_tdata[13:7]),
        .in_dir    (s_tdata[15:14]),
        .in_draw   (s_tdata[31:16]),
        .in_val    (s_tdata[33:32]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = out_reg.status;
    assign m_tdata   = {4'd0, out_reg.state_count, out_reg.changed,
                        out_reg.neighbour_state, out_reg.site_state};

    `CDL_ASSERT_IMPL(a_idle_no_result, aclk, aresetn, s_tready, !res_valid)
    `CDL_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `CDL_ASSERT_IMPL(a_error_clean, aclk, aresetn, m_tvalid && (m_tuser != cdl_pkg::STAT_OK), m_tdata[19:0] == 20'd0)
    `CDL_ASSERT_IMPL(a_changed_copy, aclk, aresetn, m_tvalid && m_tdata[4], m_tdata[3:2] == m_tdata[1:0])

endmodule
